// ----- hw/rtl/mac_address_text_parser_unit_assert.svh -----
// assertion macros for the mac address text parser
`ifndef MAC_ADDRESS_TEXT_PARSER_UNIT_ASSERT_SVH
`define MAC_ADDRESS_TEXT_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MACP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MACP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/macp_pkg.sv -----
// types, constants and helper functions for the mac address text parser
`timescale 1ns / 1ps

package macp_pkg;

   localparam int AddressBytesDefault = 6;
   localparam int MacW   = 48;
   localparam int CharW  = 8;
   localparam int GroupW = 3;
   localparam int PhaseW = 2;

   // parse phase codes
   localparam logic [PhaseW-1:0] PH_FIRST  = 2'd0;
   localparam logic [PhaseW-1:0] PH_SECOND = 2'd1;
   localparam logic [PhaseW-1:0] PH_DASH   = 2'd2;

   // character codes
   localparam logic [CharW-1:0] CHR_NUL   = 8'h00;
   localparam logic [CharW-1:0] CHR_DASH  = 8'h2d;
   localparam logic [CharW-1:0] CHR_0     = 8'h30;
   localparam logic [CharW-1:0] CHR_9     = 8'h39;
   localparam logic [CharW-1:0] CHR_LA    = 8'h61;
   localparam logic [CharW-1:0] CHR_LF    = 8'h66;
   localparam logic [CharW-1:0] CHR_UA    = 8'h41;
   localparam logic [CharW-1:0] CHR_UF    = 8'h46;
   localparam logic [CharW-1:0] CHR_SPACE = 8'h20;
   localparam logic [CharW-1:0] CHR_TAB   = 8'h09;
   localparam logic [CharW-1:0] CHR_CR    = 8'h0d;
   localparam logic [CharW-1:0] HEX_ALPHA_BASE = 8'd10;

   typedef struct packed {
      logic [CharW-1:0] text_char;
      logic             string_start;
   } req_type;

   typedef struct packed {
      logic [MacW-1:0] mac_value;
      logic            parse_ok;
   } rsp_type;

   typedef struct packed {
      logic [GroupW-1:0] group_index;
      logic [PhaseW-1:0] parse_phase;
      logic [CharW-1:0]  partial_byte;
      logic              finished;
   } ctl_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_decode(input logic [CharW-1:0] c);
      hex_type h;
      logic [CharW-1:0] v;
      h = '0;
      v = '0;
      if (c inside {[CHR_0:CHR_9]}) begin
         v = c - CHR_0;
         h.ok = 1'b1;
      end else if (c inside {[CHR_LA:CHR_LF]}) begin
         v = c - CHR_LA + HEX_ALPHA_BASE;
         h.ok = 1'b1;
      end else if (c inside {[CHR_UA:CHR_UF]}) begin
         v = c - CHR_UA + HEX_ALPHA_BASE;
         h.ok = 1'b1;
      end
      h.val = v[3:0];
      return h;
   endfunction

   // zero byte or whitespace ends the last group
   function automatic logic is_terminator(input logic [CharW-1:0] c);
      return (c inside {CHR_NUL, CHR_SPACE, [CHR_TAB:CHR_CR]});
   endfunction

endpackage

// ----- hw/rtl/macp_step.sv -----
// one-character parse step: next state and optional result
`timescale 1ns / 1ps

module macp_step #(
   parameter int ADDRESS_BYTES = macp_pkg::AddressBytesDefault
) (
   input  macp_pkg::req_type                 req_i,
   input  macp_pkg::ctl_type                 ctl_i,
   input  logic [ADDRESS_BYTES*8-1:0]        addr_i,
   output macp_pkg::ctl_type                 ctl_o,
   output logic [ADDRESS_BYTES*8-1:0]        addr_o,
   output logic                              emit_o,
   output macp_pkg::rsp_type                 rsp_o
);

   localparam int AddrW = ADDRESS_BYTES * 8;

   macp_pkg::ctl_type cur;
   macp_pkg::hex_type hx;
   logic [AddrW-1:0]  ad_cur;
   logic [AddrW-1:0]  stored;
   logic [AddrW-1:0]  stored_two;
   logic [7:0]        pb_two;
   logic              last;
   logic              ok;

   always_comb begin
      cur    = ctl_i;
      ad_cur = addr_i;
      if (req_i.string_start) begin
         cur    = '0;
         ad_cur = '0;
      end
      last       = (cur.group_index >= macp_pkg::GroupW'(ADDRESS_BYTES - 1));
      hx         = macp_pkg::hex_decode(req_i.text_char);
      pb_two     = {cur.partial_byte[3:0], hx.val};
      stored     = (ad_cur << 8) | AddrW'(cur.partial_byte);
      stored_two = (ad_cur << 8) | AddrW'(pb_two);

      ctl_o  = cur;
      addr_o = ad_cur;
      emit_o = 1'b0;
      ok     = 1'b0;

      if (!cur.finished) begin
         case (cur.parse_phase)
            macp_pkg::PH_SECOND: begin
               if (last) begin
                  emit_o = 1'b1;
                  if (macp_pkg::is_terminator(req_i.text_char)) begin
                     addr_o = stored;
                     ok     = 1'b1;
                  end else if (hx.ok) begin
                     addr_o = stored_two;
                     ok     = 1'b1;
                  end
               end else if (req_i.text_char == macp_pkg::CHR_DASH) begin
                  addr_o            = stored;
                  ctl_o.group_index = cur.group_index + 1'b1;
                  ctl_o.parse_phase = macp_pkg::PH_FIRST;
                  ctl_o.partial_byte = '0;
               end else if (!hx.ok) begin
                  emit_o = 1'b1;
               end else begin
                  ctl_o.partial_byte = pb_two;
                  ctl_o.parse_phase  = macp_pkg::PH_DASH;
               end
            end
            macp_pkg::PH_DASH: begin
               if (req_i.text_char != macp_pkg::CHR_DASH) begin
                  emit_o = 1'b1;
               end else begin
                  addr_o             = stored;
                  ctl_o.group_index  = cur.group_index + 1'b1;
                  ctl_o.parse_phase  = macp_pkg::PH_FIRST;
                  ctl_o.partial_byte = '0;
               end
            end
            default: begin
               // first digit of a group; unused phase code behaves the same
               if (!hx.ok) begin
                  emit_o = 1'b1;
               end else begin
                  ctl_o.partial_byte = {4'h0, hx.val};
                  ctl_o.parse_phase  = macp_pkg::PH_SECOND;
               end
            end
         endcase
      end

      if (emit_o) begin
         ctl_o.finished = 1'b1;
      end

      rsp_o.parse_ok  = ok;
      rsp_o.mac_value = ok ? macp_pkg::MacW'(addr_o) : '0;
   end

endmodule

// ----- hw/rtl/mac_address_text_parser_unit.sv -----
// top level of the mac address text parser
`timescale 1ns / 1ps
//
// usage
// - req channel (req_valid / req_ready / req_data) carries one character per
//   transaction; string_start marks the first character of a new address
//   text, a zero byte or whitespace may end it
// - rsp channel (rsp_valid / rsp_ready / rsp_data) carries at most one
//   transaction per string: the address with parse_ok set, or zero with
//   parse_ok clear at the first malformed character
// - characters after a result, and characters before any string_start, are
//   absorbed without a response
// - a character accepted into the input register shows its result on rsp once
//   the step consumes it and loads the result register (input register, then result register)
// - throughput: one character per cycle while the result register has room;
//   the parse state (ctl_ff, addr_ff) is updated by one combinational step per character
// - when the receiver stalls with a result pending, the input register still
//   takes one more character, which then waits until rsp_ready frees the
//   result register; req_ready drops only while both registers are occupied
// - reset: synchronous, active high; both registers empty, parser idle
//   until the next string_start
//
module mac_address_text_parser_unit #(
   parameter int ADDRESS_BYTES = macp_pkg::AddressBytesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  macp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output macp_pkg::rsp_type rsp_data
);

`include "mac_address_text_parser_unit_assert.svh"

   localparam int AddrW = ADDRESS_BYTES * 8;

   // input register
   logic              in_valid_ff, in_valid_in;
   macp_pkg::req_type in_ff, in_in;

   // parse state
   macp_pkg::ctl_type ctl_ff, ctl_in;
   logic [AddrW-1:0]  addr_ff, addr_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   macp_pkg::rsp_type rsp_ff, rsp_in;

   // step outputs
   macp_pkg::ctl_type step_ctl;
   logic [AddrW-1:0]  step_addr;
   logic              step_emit;
   macp_pkg::rsp_type step_rsp;

   logic advance;

   macp_step #(
      .ADDRESS_BYTES(ADDRESS_BYTES)
   ) u_step (
      .req_i (in_ff),
      .ctl_i (ctl_ff),
      .addr_i(addr_ff),
      .ctl_o (step_ctl),
      .addr_o(step_addr),
      .emit_o(step_emit),
      .rsp_o (step_rsp)
   );

   // the held character is consumed once the result register has room
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_in       = req_data;
      end

      ctl_in  = ctl_ff;
      addr_in = addr_ff;
      if (advance) begin
         ctl_in  = step_ctl;
         addr_in = step_addr;
      end

      // result register: load on emit, clear when taken
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_valid_in = step_emit;
         if (step_emit) begin
            rsp_in = step_rsp;
         end
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         // parser idle until the next string_start
         ctl_ff       <= '{finished: 1'b1, default: '0};
         addr_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ctl_ff       <= ctl_in;
         addr_ff      <= addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a failed parse never carries an address
   `MACP_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_data.parse_ok,
      rsp_data.mac_value == '0, "failure result with nonzero address")

   // a held character is not overwritten while it waits
   `MACP_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_ff), "input register lost a waiting character")

   // every emitted result leaves the parser idle
   `MACP_ASSERT_NEXT(a_emit_idle, clock, reset, advance && step_emit,
      ctl_ff.finished && rsp_valid_ff, "parser not idle after a result")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the mac address text parser unit
module tb;
   import macp_pkg::*;

   localparam int ADDR_BYTES = AddressBytesDefault;
   // characters sent after which the random part stops
   localparam int TEXT_GOAL  = 900;

   // how a directed row is checked: by the parse model, by a typed expectation, or not at all
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} chk_kind_type;

   typedef struct packed {
      logic [CharW-1:0] text_char;
      logic             string_start;
      chk_kind_type     chk;
      logic [MacW-1:0]  mac;
      logic             ok;
   } dir_row_type;

   // clock and reset
   logic    clock = 1'b0;
   logic    reset = 1'b1;

   // block ports, known values from time zero
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // while set, neither side idles
   logic    calm = 1'b0;

   // parse model state
   logic [GroupW-1:0] p_group   = '0;
   logic [PhaseW-1:0] p_phase   = PH_FIRST;
   logic [CharW-1:0]  p_partial = '0;
   logic [63:0]       p_addr    = '0;
   bit                p_idle    = 1'b1;

   // addresses and failures still owed by the block, oldest first
   rsp_type addr_q[$];

   int errors       = 0;
   int chars_sent   = 0;
   int n_strings    = 0;
   int n_noise      = 0;
   int n_good       = 0;
   int n_bad        = 0;

   // directed text: idle character, early end, non-ascii byte, restart
   // mid-parse, full address in mixed case ending on its second digit,
   // ignored character after a result, missing dash, dash as first character
   dir_row_type directed_rows [0:20] = '{
      '{CHR_UA,   1'b0, CHK_NONE,   48'h0, 1'b0},
      '{CHR_NUL,  1'b1, CHK_RESULT, 48'h0, 1'b0},
      '{8'hff,    1'b1, CHK_RESULT, 48'h0, 1'b0},
      '{8'h37,    1'b1, CHK_NONE,   48'h0, 1'b0},
      '{CHR_UF,   1'b1, CHK_NONE,   48'h0, 1'b0},
      '{CHR_DASH, 1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_LF,   1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_DASH, 1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_0,    1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_DASH, 1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_9,    1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_DASH, 1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_LA,   1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_DASH, 1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_UA,   1'b0, CHK_MODEL,  48'h0, 1'b0},
      '{CHR_LF,   1'b0, CHK_RESULT, 48'h0f0f_0009_0aaf, 1'b1},
      '{CHR_DASH, 1'b0, CHK_NONE,   48'h0, 1'b0},
      '{8'h63,    1'b1, CHK_NONE,   48'h0, 1'b0},
      '{8'h42,    1'b0, CHK_NONE,   48'h0, 1'b0},
      '{8'h63,    1'b0, CHK_RESULT, 48'h0, 1'b0},
      '{CHR_DASH, 1'b1, CHK_RESULT, 48'h0, 1'b0}
   };

   mac_address_text_parser_unit #(.ADDRESS_BYTES(ADDR_BYTES)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // one character through the parse model; produced marks a finished string
   task automatic parse_char(input req_type r, output bit produced, output rsp_type res);
      logic [CharW-1:0] c;
      bit               last;
      bit               is_hex;
      bit               is_ws;
      bit               ok;
      logic [3:0]       nib;
      c        = r.text_char;
      produced = 1'b0;
      res      = '0;
      ok       = 1'b0;
      last     = (p_group >= ADDR_BYTES - 1);
      if (r.string_start) begin
         p_group   = '0;
         p_phase   = PH_FIRST;
         p_partial = '0;
         p_addr    = '0;
         p_idle    = 1'b0;
         last      = (ADDR_BYTES - 1 <= 0);
      end
      if (p_idle) return;

      // hex digit in either case
      is_hex = 1'b1;
      nib    = '0;
      if (c >= CHR_0 && c <= CHR_9) nib = 4'(c - CHR_0);
      else if (c >= CHR_LA && c <= CHR_LF) nib = 4'(c - CHR_LA + 8'd10);
      else if (c >= CHR_UA && c <= CHR_UF) nib = 4'(c - CHR_UA + 8'd10);
      else is_hex = 1'b0;
      is_ws = (c == CHR_SPACE) || (c >= CHR_TAB && c <= CHR_CR);

      case (p_phase)
         PH_SECOND: begin
            if (last) begin
               // last group ends on a terminator or on its second digit
               if (c == CHR_NUL || is_ws) begin
                  p_addr   = {p_addr[55:0], p_partial};
                  ok       = 1'b1;
                  produced = 1'b1;
               end else if (!is_hex) begin
                  produced = 1'b1;
               end else begin
                  p_partial = {p_partial[3:0], nib};
                  p_addr    = {p_addr[55:0], p_partial};
                  ok        = 1'b1;
                  produced  = 1'b1;
               end
            end else if (c == CHR_DASH) begin
               p_addr    = {p_addr[55:0], p_partial};
               p_group   = p_group + 1'b1;
               p_phase   = PH_FIRST;
               p_partial = '0;
            end else if (!is_hex) begin
               produced = 1'b1;
            end else begin
               p_partial = {p_partial[3:0], nib};
               p_phase   = PH_DASH;
            end
         end
         PH_DASH: begin
            if (c != CHR_DASH) begin
               produced = 1'b1;
            end else begin
               p_addr    = {p_addr[55:0], p_partial};
               p_group   = p_group + 1'b1;
               p_phase   = PH_FIRST;
               p_partial = '0;
            end
         end
         default: begin
            // first digit of a group; the unused phase code lands here too
            if (!is_hex) begin
               produced = 1'b1;
            end else begin
               p_partial = {4'h0, nib};
               p_phase   = PH_SECOND;
            end
         end
      endcase

      if (produced) begin
         res.mac_value = ok ? p_addr[MacW-1:0] : '0;
         res.parse_ok  = ok;
         p_idle        = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= 40) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (got.parse_ok === 1'b1) n_good++;
      else n_bad++;
      if (addr_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result mac %h ok %b",
                                   got.mac_value, got.parse_ok));
         return;
      end
      want = addr_q.pop_front();
      if (got.mac_value !== want.mac_value)
         report_mismatch($sformatf("mac_value %h, want %h", got.mac_value, want.mac_value));
      if (got.parse_ok !== want.parse_ok)
         report_mismatch($sformatf("parse_ok %b, want %b", got.parse_ok, want.parse_ok));
   endtask

   // one req transaction: optional idle gap, then hold valid until accepted.
   // ready is sampled at the falling edge, where everything is settled
   task automatic drive_char(input req_type r, output bit produced, output rsp_type res);
      if (!calm) begin
         while ($urandom_range(99) < 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      // accepted at this edge
      parse_char(r, produced, res);
      chars_sent++;
   endtask

   task automatic send_char(input req_type r);
      bit      produced;
      rsp_type res;
      drive_char(r, produced, res);
      if (produced) addr_q = {addr_q, res};
   endtask

   // sender stops until the block has handed back everything owed
   task automatic hold_until_empty();
      req_valid <= 1'b0;
      @(posedge clock);
      while (addr_q.size() != 0) @(posedge clock);
   endtask

   // one address text with random digits, case and terminator; when
   // corrupt is set one spot is broken or the text is cut short
   task automatic send_address_text(input bit corrupt);
      req_type    txt[$];
      req_type    r;
      int         ndig;
      int         pos;
      int         k;
      logic [3:0] nib;
      n_strings++;
      for (int g = 0; g < ADDR_BYTES; g++) begin
         ndig = $urandom_range(1, 2);
         for (int d = 0; d < ndig; d++) begin
            nib            = 4'($urandom_range(15));
            r.string_start = (txt.size() == 0);
            if (nib < 10) r.text_char = CHR_0 + nib;
            else r.text_char = ($urandom_range(1) ? CHR_UA : CHR_LA) + nib - 8'd10;
            txt = {txt, r};
         end
         r.string_start = 1'b0;
         if (g < ADDR_BYTES - 1) begin
            r.text_char = CHR_DASH;
            txt = {txt, r};
         end else if (ndig == 1) begin
            // zero byte, space, or one of tab .. carriage return
            k = $urandom_range(6);
            if (k == 0) r.text_char = CHR_NUL;
            else if (k == 1) r.text_char = CHR_SPACE;
            else r.text_char = CHR_TAB + 8'(k - 2);
            txt = {txt, r};
         end
      end
      // characters after the result are ignored by the block
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            r.string_start = 1'b0;
            r.text_char    = 8'($urandom_range(255));
            txt = {txt, r};
         end
      end
      if (corrupt) begin
         pos = $urandom_range(txt.size() - 1);
         r   = txt[pos];
         case ($urandom_range(3))
            0: r.text_char = 8'($urandom_range(255));
            1: r.text_char = CHR_NUL;
            2: r.string_start = 1'b1;
            default: begin
               while (txt.size() > pos + 1) void'(txt.pop_back());
            end
         endcase
         txt[pos] = r;
      end
      foreach (txt[i]) send_char(txt[i]);
   endtask

   // receiver: stalls now and then, never while calm
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 6);
   end

   // rsp transaction seen at the falling edge is taken at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);
   end

   initial begin : stimulus
      dir_row_type row;
      req_type     r;
      rsp_type     res;
      rsp_type     typed;
      bit          produced;
      bit          mid_hold;
      int          pick;
      mid_hold = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed_rows[i]) begin
         row            = directed_rows[i];
         r.text_char    = row.text_char;
         r.string_start = row.string_start;
         drive_char(r, produced, res);
         case (row.chk)
            CHK_MODEL: begin
               if (produced) addr_q = {addr_q, res};
            end
            CHK_RESULT: begin
               typed.mac_value = row.mac;
               typed.parse_ok  = row.ok;
               addr_q = {addr_q, typed};
            end
            default: ;
         endcase
      end
      hold_until_empty();

      // random part: mostly well formed text, some broken, some noise
      while (chars_sent < TEXT_GOAL) begin
         calm <= (chars_sent >= 300 && chars_sent < 450);
         pick = $urandom_range(99);
         if (pick < 10) begin
            n_noise++;
            repeat ($urandom_range(1, 4)) begin
               r.text_char    = 8'($urandom_range(255));
               r.string_start = ($urandom_range(2) == 0);
               send_char(r);
            end
         end else begin
            send_address_text(pick < 35);
         end
         if (!mid_hold && chars_sent > 500) begin
            hold_until_empty();
            mid_hold = 1'b1;
         end
      end

      // drain, then wait on for anything still in the pipeline
      hold_until_empty();
      repeat (10) @(posedge clock);

      $display("run covered %0d characters in %0d address texts and %0d noise bursts",
               chars_sent, n_strings, n_noise);
      $display("results seen: %0d addresses, %0d malformed texts, %0d mismatches",
               n_good, n_bad, errors);
      if (errors == 0 && addr_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", addr_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
